FILE: hdl/ising_metropolis_site_update_top_defines.svh
// Assertion macros for the Ising site update block.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ISING_METROPOLIS_SITE_UPDATE_TOP_DEFINES_SVH
`define ISING_METROPOLIS_SITE_UPDATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define ISM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ism: same-cycle check failed");
`define ISM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ism: next-cycle check failed");
`else
`define ISM_ASSERT_IMP(label, ante, cons)
`define ISM_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: hdl/ism_pkg.sv
package ism_pkg;

	// Lattice geometry.
	localparam int LATTICE_SIDE = 32;
	localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
	localparam int ROW_W        = $clog2(LATTICE_SIDE);

	// Field widths of one request and one result.
	localparam int COORD_W = 5;
	localparam int DRAW_W  = 16;
	localparam int MAG_W   = 12;
	localparam int IN_W    = 32;
	localparam int OUT_W   = 16;

	// Threshold registers: two 17-bit fractions per neighbor sum.
	localparam int CFG_COUNT = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 34;
	localparam int THR_W     = 17;
	localparam logic [CFG_W-1:0] CFG_RESET = 34'h2_0001_0000;

	localparam logic [MAG_W-1:0] MAG_RESET = MAG_W'(SITE_COUNT % (1 << MAG_W));

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SUM_M4   = 3'd0,
		REG_SUM_M2   = 3'd1,
		REG_SUM_ZERO = 3'd2,
		REG_SUM_P2   = 3'd3,
		REG_SUM_P4   = 3'd4
	} cfg_reg_t;

	typedef logic [CFG_COUNT-1:0][CFG_W-1:0] thr_regs_t;
	typedef logic [LATTICE_SIDE-1:0]         spin_row_t;

	// Request bundle from the update engine to the spin memory.
	typedef struct packed {
		logic             we;
		logic [ROW_W-1:0] waddr;
		spin_row_t        wdata;
		logic             re_a;
		logic [ROW_W-1:0] raddr_a;
		logic             re_b;
		logic [ROW_W-1:0] raddr_b;
	} mem_req_t;

	typedef struct packed {
		logic clearing;
		logic res_load;
	} status_t;

	// Reduce a raw coordinate modulo the lattice side through a small table.
	function automatic logic [ROW_W-1:0] wrap_coord(input logic [COORD_W-1:0] v);
		logic [ROW_W-1:0] r;
		r = '0;
		for (int i = 0; i < (1 << COORD_W); i++) begin
			if (v == COORD_W'(i)) begin
				r = ROW_W'(i % LATTICE_SIDE);
			end
		end
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] coord_dec(input logic [ROW_W-1:0] v);
		return (v == '0) ? ROW_W'(LATTICE_SIDE - 1) : ROW_W'(v - 1'b1);
	endfunction

	function automatic logic [ROW_W-1:0] coord_inc(input logic [ROW_W-1:0] v);
		return (v == ROW_W'(LATTICE_SIDE - 1)) ? '0 : ROW_W'(v + 1'b1);
	endfunction

endpackage

FILE: hdl/ism_ram.sv
module ism_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic                     re_b,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: hdl/ism_cfg.sv
module ism_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ism_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ism_pkg::CFG_W-1:0]      cfg_wdata,
	output ism_pkg::thr_regs_t             thr_regs
);
	import ism_pkg::*;

	thr_regs_t thr_q;

	// Writes to indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= {CFG_COUNT{CFG_RESET}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SUM_M4:   thr_q[0] <= cfg_wdata;
				REG_SUM_M2:   thr_q[1] <= cfg_wdata;
				REG_SUM_ZERO: thr_q[2] <= cfg_wdata;
				REG_SUM_P2:   thr_q[3] <= cfg_wdata;
				REG_SUM_P4:   thr_q[4] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign thr_regs = thr_q;

endmodule

FILE: hdl/ism_core.sv
module ism_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ism_pkg::COORD_W-1:0]   in_row,
	input  logic [ism_pkg::COORD_W-1:0]   in_col,
	input  logic [ism_pkg::DRAW_W-1:0]    in_draw,
	input  ism_pkg::thr_regs_t            thr_regs,
	output ism_pkg::mem_req_t             mem_req,
	input  ism_pkg::spin_row_t            rdata_a,
	input  ism_pkg::spin_row_t            rdata_b,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_flip,
	output logic                          out_spin,
	output logic [ism_pkg::MAG_W-1:0]     out_mag,
	output ism_pkg::status_t              status
);
	import ism_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_RD2   = 4'b0100,
		S_EVAL  = 4'b1000
	} state_t;

	state_t           state_q;
	logic [ROW_W-1:0] clr_row_q;
	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] col_q;
	logic [DRAW_W-1:0] draw_q;
	spin_row_t        here_row_q;
	logic             up_bit_q;
	logic             out_valid_q;
	logic             out_flip_q;
	logic             out_spin_q;
	logic [MAG_W-1:0] mag_q;

	logic             take;
	logic             res_load;
	logic [ROW_W-1:0] in_row_w;
	logic             dn_bit;
	logic [2:0]       ups;
	logic [CFG_W-1:0] thr_word;
	logic [THR_W-1:0] thr;
	logic             cur_up;
	logic             new_up;
	logic             accept;
	spin_row_t        new_row;

	assign in_ready = (state_q == S_IDLE);
	assign take     = in_valid && in_ready;
	assign res_load = (state_q == S_EVAL) && (!out_valid_q || out_ready);
	assign in_row_w = wrap_coord(in_row);

	// Neighbor count and acceptance test on the three fetched rows.
	always_comb begin
		dn_bit   = rdata_b[col_q];
		ups      = 3'(here_row_q[coord_dec(col_q)]) + 3'(here_row_q[coord_inc(col_q)])
			+ 3'(up_bit_q) + 3'(dn_bit);
		thr_word = thr_regs[ups];
		cur_up   = here_row_q[col_q];
		new_up   = !cur_up;
		thr      = new_up ? thr_word[2*THR_W-1:THR_W] : thr_word[THR_W-1:0];
		accept   = ({1'b0, draw_q} < thr);
		new_row  = here_row_q;
		new_row[col_q] = new_up;
	end

	// Reads: site row and row above on take, row below in S_RD2; writes: clear or flip.
	always_comb begin
		mem_req         = '0;
		mem_req.re_a    = take;
		mem_req.raddr_a = in_row_w;
		mem_req.re_b    = take || (state_q == S_RD2);
		mem_req.raddr_b = (state_q == S_RD2) ? coord_inc(row_q) : coord_dec(in_row_w);
		if (state_q == S_CLEAR) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = clr_row_q;
			mem_req.wdata = '1;
		end else begin
			mem_req.we    = res_load && accept;
			mem_req.waddr = row_q;
			mem_req.wdata = new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_row_q   <= '0;
			out_valid_q <= 1'b0;
			mag_q       <= MAG_RESET;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_row_q <= ROW_W'(clr_row_q + 1'b1);
					if (clr_row_q == ROW_W'(LATTICE_SIDE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (take) begin
						state_q <= S_RD2;
					end
				end
				S_RD2: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (res_load) begin
						if (accept) begin
							mag_q <= new_up ? MAG_W'(mag_q + 2'd2) : MAG_W'(mag_q - 2'd2);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take) begin
			row_q  <= in_row_w;
			col_q  <= wrap_coord(in_col);
			draw_q <= in_draw;
		end
		if (state_q == S_RD2) begin
			here_row_q <= rdata_a;
			up_bit_q   <= rdata_b[col_q];
		end
		if (res_load) begin
			out_flip_q <= accept;
			out_spin_q <= accept ? new_up : cur_up;
		end
	end

	assign out_valid = out_valid_q;
	assign out_flip  = out_flip_q;
	assign out_spin  = out_spin_q;
	assign out_mag   = mag_q;

	assign status.clearing = (state_q == S_CLEAR);
	assign status.res_load = res_load;

endmodule

FILE: hdl/ising_metropolis_site_update_top.sv
// A request is taken only in the idle state; the site row and the row above are read
// through the two read ports of the spin RAM then, the row below in the second-read
// state. An accepted flip writes back the site row, and the block returns to idle as
// its result is registered. Reset: arst_n clears control state at once and loads the
// thresholds and magnetization; a clearing pass over 32 rows then sets every spin up.
`include "ising_metropolis_site_update_top_defines.svh"

module ising_metropolis_site_update_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// Request channel. tdata, low bit up: site_row[4:0], site_col[9:5],
	// uniform_draw[25:10], zero fill [31:26].
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [ism_pkg::IN_W-1:0]      s_axis_tdata,
	// Result channel. tdata, low bit up: flip_accepted[0], site_spin_up[1],
	// magnetization[13:2], zero fill [15:14].
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [ism_pkg::OUT_W-1:0]     m_axis_tdata,
	// Threshold register writes.
	input  logic                          cfg_we,
	input  logic [ism_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ism_pkg::CFG_W-1:0]     cfg_wdata
);
	import ism_pkg::*;

	thr_regs_t        thr_regs;
	mem_req_t         mem_req;
	spin_row_t        rdata_a;
	spin_row_t        rdata_b;
	status_t          status;
	logic             out_flip;
	logic             out_spin;
	logic [MAG_W-1:0] out_mag;

	// The five threshold pairs, one per neighbor sum from -4 to +4.
	ism_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.thr_regs  (thr_regs)
	);

	// The lattice is stored one row per word, so the left, right and center spins
	// arrive together and the rows above and below take one more read each.
	ism_ram #(
		.WIDTH (LATTICE_SIDE),
		.DEPTH (LATTICE_SIDE)
	) u_spin_ram (
		.clk     (clk),
		.we      (mem_req.we),
		.waddr   (mem_req.waddr),
		.wdata   (mem_req.wdata),
		.re_a    (mem_req.re_a),
		.raddr_a (mem_req.raddr_a),
		.rdata_a (rdata_a),
		.re_b    (mem_req.re_b),
		.raddr_b (mem_req.raddr_b),
		.rdata_b (rdata_b)
	);

	// The update engine handles one request at a time, so the write-back of one
	// request always lands before the reads of the next and no forwarding is needed.
	ism_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_row    (s_axis_tdata[COORD_W-1:0]),
		.in_col    (s_axis_tdata[2*COORD_W-1:COORD_W]),
		.in_draw   (s_axis_tdata[2*COORD_W+DRAW_W-1:2*COORD_W]),
		.thr_regs  (thr_regs),
		.mem_req   (mem_req),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_flip  (out_flip),
		.out_spin  (out_spin),
		.out_mag   (out_mag),
		.status    (status)
	);

	assign m_axis_tdata = {(OUT_W - MAG_W - 2)'(0), out_mag, out_spin, out_flip};

	// No request is taken while the lattice is still being cleared.
	`ISM_ASSERT_IMP(a_no_take_clearing, status.clearing, !s_axis_tready)
	// A request that is taken is never followed by another in the next cycle.
	`ISM_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// A result that has not been taken is never overwritten.
	`ISM_ASSERT_IMP(a_no_overwrite, m_axis_tvalid && !m_axis_tready, !status.res_load)
	// Writes to the spin RAM happen only while clearing or when a result is produced.
	`ISM_ASSERT_IMP(a_write_source, mem_req.we, status.clearing || status.res_load)

endmodule

FILE: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ism_pkg::*;

	// Request and result layouts on the stream buses, first field in the low bits.
	typedef struct packed {
		logic [IN_W-2*COORD_W-DRAW_W-1:0] fill;
		logic [DRAW_W-1:0]                draw;
		logic [COORD_W-1:0]               col;
		logic [COORD_W-1:0]               row;
	} site_request_t;

	typedef struct packed {
		logic [OUT_W-MAG_W-3:0] fill;
		logic [MAG_W-1:0]       magnetization;
		logic                   spin_up;
		logic                   accepted;
	} site_result_t;

	localparam int CYCLE_LIMIT       = 600000;
	localparam int DRAIN_CYCLES      = 8;
	localparam int SPARE_INDEX_FIRST = CFG_COUNT;
	localparam int INDEX_SPACE       = 1 << CFG_IDX_W;
	localparam int DRAW_MAX          = (1 << DRAW_W) - 1;
	localparam int ALWAYS_ACCEPT     = 1 << DRAW_W;
	localparam int THR_MAX           = (1 << THR_W) - 1;
	localparam int RANDOM_PHASES     = 6;
	localparam int ITEMS_PER_PHASE   = 155;

	// Shadow copy of the lattice. Every accepted request is played against it
	// at once, and the outcome it predicts waits in a queue for the block's result.
	class ising_lattice_shadow;
		spin_row_t          spins [LATTICE_SIDE];
		logic [MAG_W-1:0]   magnetization;
		logic [CFG_W-1:0]   thresholds [CFG_COUNT];
		site_result_t       outcomes_due [$];
		int                 mismatches;
		int                 results_checked;
		int                 flips_accepted;
		int                 upcount_hits [CFG_COUNT];

		function new();
			foreach (spins[r]) spins[r] = '1;
			foreach (thresholds[i]) thresholds[i] = CFG_RESET;
			foreach (upcount_hits[i]) upcount_hits[i] = 0;
			magnetization = MAG_RESET;
			mismatches = 0;
			results_checked = 0;
			flips_accepted = 0;
		endfunction

		// Writes to indexes past the last register are dropped by the block.
		function void write_threshold(input int index, input logic [CFG_W-1:0] value);
			if (index < CFG_COUNT) begin
				thresholds[index] = value;
			end
		endfunction

		function void note_request(input site_request_t req);
			int               row;
			int               col;
			int               row_above;
			int               row_below;
			int               col_left;
			int               col_right;
			int               ups;
			logic             new_up;
			logic [THR_W-1:0] limit;
			site_result_t     want;
			row       = int'(req.row) % LATTICE_SIDE;
			col       = int'(req.col) % LATTICE_SIDE;
			row_above = (row + LATTICE_SIDE - 1) % LATTICE_SIDE;
			row_below = (row + 1) % LATTICE_SIDE;
			col_left  = (col + LATTICE_SIDE - 1) % LATTICE_SIDE;
			col_right = (col + 1) % LATTICE_SIDE;
			ups = int'(spins[row_above][col]) + int'(spins[row_below][col])
				+ int'(spins[row][col_left]) + int'(spins[row][col_right]);
			upcount_hits[ups]++;
			new_up = ~spins[row][col];
			limit  = new_up ? thresholds[ups][2*THR_W-1:THR_W] : thresholds[ups][THR_W-1:0];
			want = '0;
			want.accepted = ({1'b0, req.draw} < limit);
			if (want.accepted) begin
				spins[row][col] = new_up;
				magnetization = new_up ? magnetization + MAG_W'(2) : magnetization - MAG_W'(2);
			end
			want.spin_up = spins[row][col];
			want.magnetization = magnetization;
			outcomes_due.push_back(want);
		endfunction

		function void check_result(input site_result_t got);
			site_result_t want;
			if (outcomes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result %h arrived with no request outstanding", $time, got);
				end
				return;
			end
			want = outcomes_due.pop_front();
			results_checked++;
			if (got.accepted) flips_accepted++;
			if (got.accepted !== want.accepted || got.spin_up !== want.spin_up
					|| got.magnetization !== want.magnetization) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result %0d accepted %b/%b spin_up %b/%b magnetization %0d/%0d (expected/actual)",
						$time, results_checked, want.accepted, got.accepted, want.spin_up,
						got.spin_up, $signed(want.magnetization), $signed(got.magnetization));
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	ising_lattice_shadow shadow;
	logic [CFG_W-1:0]    register_image [INDEX_SPACE];
	logic                steady_flow = 1'b0;
	int                  settings_used = 0;
	int                  cycle_count = 0;
	int                  stall_left = 0;

	ising_metropolis_site_update_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog. The slowest legal run is far below this even with every gap
	// and every stall at its longest.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, shadow.outcomes_due.size());
			$display("FAIL");
			$finish;
		end
	end

	// Mostly back to back, sometimes a short pause, rarely a long one.
	function automatic int idle_gap();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55) return 0;
		if (pick < 85) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// A threshold half drawn so that never, always and the edges near the
	// draw range come up often.
	function automatic logic [THR_W-1:0] pick_threshold();
		case ($urandom_range(9))
			0: return '0;
			1: return THR_W'(1);
			2: return THR_W'(DRAW_MAX);
			3: return THR_W'(ALWAYS_ACCEPT);
			4: return THR_W'(THR_MAX);
			5: return THR_W'($urandom_range(ALWAYS_ACCEPT + 1, THR_MAX));
			default: return THR_W'($urandom_range(0, DRAW_MAX));
		endcase
	endfunction

	// The result side holds tready low for a random stretch now and then,
	// except while the current phase runs at full rate.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!steady_flow && $urandom_range(99) < 20) begin
			stall_left = idle_gap();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Both buses are sampled at the clock edge with the values that held before it.
	// A result can never share an edge with its own request, so checking first is safe.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				shadow.check_result(site_result_t'(m_axis_tdata));
			end
			if (s_axis_tvalid && s_axis_tready) begin
				shadow.note_request(site_request_t'(s_axis_tdata));
			end
		end
	end

	// Presents one request and returns at the edge that accepts it. tvalid is
	// left high so that a following request can go out back to back.
	task automatic send_site(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
			input logic [DRAW_W-1:0] draw);
		int            gap;
		site_request_t req;
		gap = steady_flow ? 0 : idle_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req = '0;
		req.row = row;
		req.col = col;
		req.draw = draw;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= req;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Writes register_image[first..last_index] one per cycle.
	task automatic program_registers(input int first, input int last_index);
		for (int i = first; i <= last_index; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= register_image[i];
			@(posedge clk);
			shadow.write_threshold(i, register_image[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// Stops sending and waits until every outstanding result is back, plus the
	// pipeline depth, so that the block is idle for the next register writes.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (shadow.outcomes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int                  row;
		int                  col;
		int                  draw;
		int                  limit;
		logic [CFG_W-1:0]    reg_value;
		logic [THR_W-1:0]    up_half;
		logic [THR_W-1:0]    down_half;

		shadow = new();
		foreach (register_image[i]) register_image[i] = CFG_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Writes past the last register must leave the reset thresholds alone.
		// The reset thresholds are all 65536, so every flip below must still go through.
		for (int i = SPARE_INDEX_FIRST; i < INDEX_SPACE; i++) register_image[i] = '0;
		program_registers(SPARE_INDEX_FIRST, INDEX_SPACE - 1);
		settings_used++;

		// Corners of the lattice at both draw extremes; their neighbors wrap around.
		send_site(COORD_W'(0), COORD_W'(0), DRAW_W'(DRAW_MAX));
		send_site(COORD_W'(LATTICE_SIDE - 1), COORD_W'(LATTICE_SIDE - 1), DRAW_W'(DRAW_MAX));
		send_site(COORD_W'(0), COORD_W'(LATTICE_SIDE - 1), DRAW_W'(0));
		send_site(COORD_W'(LATTICE_SIDE - 1), COORD_W'(0), DRAW_W'(0));
		send_site(COORD_W'(0), COORD_W'(0), DRAW_W'(DRAW_MAX));

		// Turn all four neighbors of one site down, then flip it with none up.
		send_site(COORD_W'(19), COORD_W'(20), DRAW_W'(1));
		send_site(COORD_W'(21), COORD_W'(20), DRAW_W'(1));
		send_site(COORD_W'(20), COORD_W'(19), DRAW_W'(1));
		send_site(COORD_W'(20), COORD_W'(21), DRAW_W'(1));
		send_site(COORD_W'(20), COORD_W'(20), DRAW_W'(DRAW_MAX));
		send_site(COORD_W'(20), COORD_W'(20), DRAW_W'(0));
		settle();

		// Zero thresholds: nothing is accepted, not even a draw of zero.
		for (int i = 0; i < CFG_COUNT; i++) register_image[i] = '0;
		program_registers(0, CFG_COUNT - 1);
		settings_used++;
		send_site(COORD_W'(0), COORD_W'(0), DRAW_W'(0));
		send_site(COORD_W'(LATTICE_SIDE - 1), COORD_W'(LATTICE_SIDE - 1), DRAW_W'(0));
		send_site(COORD_W'(15), COORD_W'(16), DRAW_W'(0));
		settle();

		// Thresholds right at the draw edges: flipping down passes only a draw
		// of zero, flipping up fails only the largest draw. The sum of minus four
		// register goes to its maximum instead.
		for (int i = 0; i < CFG_COUNT; i++) begin
			register_image[i] = {THR_W'(DRAW_MAX), THR_W'(1)};
		end
		register_image[REG_SUM_M4] = '1;
		program_registers(0, CFG_COUNT - 1);
		settings_used++;
		send_site(COORD_W'(5), COORD_W'(5), DRAW_W'(1));
		send_site(COORD_W'(5), COORD_W'(5), DRAW_W'(0));
		send_site(COORD_W'(5), COORD_W'(5), DRAW_W'(DRAW_MAX));
		send_site(COORD_W'(5), COORD_W'(5), DRAW_W'(DRAW_MAX - 1));
		send_site(COORD_W'(20), COORD_W'(20), DRAW_W'(DRAW_MAX));
		send_site(COORD_W'(10), COORD_W'(10), DRAW_W'(DRAW_MAX));
		settle();

		// Random phases, each with its own set of thresholds.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			for (int i = 0; i < CFG_COUNT; i++) begin
				case (phase)
					0: reg_value = CFG_W'({$urandom, $urandom});
					3: reg_value = '1;
					RANDOM_PHASES - 1: begin
						// Shaped like a real Metropolis table: moves toward
						// alignment with the neighbors always pass.
						up_half   = (i >= 2) ? THR_W'(ALWAYS_ACCEPT)
							: THR_W'($urandom_range(0, DRAW_MAX));
						down_half = (i <= 2) ? THR_W'(ALWAYS_ACCEPT)
							: THR_W'($urandom_range(0, DRAW_MAX));
						reg_value = {up_half, down_half};
					end
					default: reg_value = {pick_threshold(), pick_threshold()};
				endcase
				register_image[i] = reg_value;
			end
			program_registers(0, CFG_COUNT - 1);
			if (phase == 2) begin
				for (int i = SPARE_INDEX_FIRST; i < INDEX_SPACE; i++) begin
					register_image[i] = CFG_W'({$urandom, $urandom});
				end
				program_registers(SPARE_INDEX_FIRST, INDEX_SPACE - 1);
			end
			settings_used++;
			steady_flow = (phase == 3) || ($urandom_range(3) == 0);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Three in ten of the sites sit in the window across the wrap corner,
				// so that neighbors there get flipped over and over.
				if ($urandom_range(99) < 30) begin
					row = (LATTICE_SIDE - 2 + $urandom_range(3)) % LATTICE_SIDE;
					col = (LATTICE_SIDE - 2 + $urandom_range(3)) % LATTICE_SIDE;
				end else begin
					row = $urandom_range(LATTICE_SIDE - 1);
					col = $urandom_range(LATTICE_SIDE - 1);
				end
				case ($urandom_range(19))
					0: draw = 0;
					1: draw = DRAW_MAX;
					2, 3: begin
						// Land on or just below one of the live thresholds.
						reg_value = shadow.thresholds[$urandom_range(CFG_COUNT - 1)];
						limit = $urandom_range(1) ? int'(reg_value[2*THR_W-1:THR_W])
							: int'(reg_value[THR_W-1:0]);
						if (limit > DRAW_MAX) draw = $urandom_range(DRAW_MAX);
						else if (limit == 0) draw = 0;
						else draw = limit - $urandom_range(1);
					end
					default: draw = $urandom_range(DRAW_MAX);
				endcase
				send_site(COORD_W'(row), COORD_W'(col), DRAW_W'(draw));
			end
			settle();
			steady_flow = 1'b0;
		end

		$display("Checked %0d site updates (%0d flips accepted) over %0d threshold settings.",
			shadow.results_checked, shadow.flips_accepted, settings_used);
		$display("Proposals by up-neighbor count 0..4: %0d %0d %0d %0d %0d; mismatches: %0d.",
			shadow.upcount_hits[0], shadow.upcount_hits[1], shadow.upcount_hits[2],
			shadow.upcount_hits[3], shadow.upcount_hits[4], shadow.mismatches);
		if (shadow.mismatches == 0 && shadow.outcomes_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
